/* rtl/core/rtpl16_pkg.sv */
// ----------------------------------------------------------------------------
// rtpl16_pkg
// Shared types and constants of the RTP L16 packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpl16_pkg;

  localparam int FRAMES_PER_PACKET_DEF = 256;
  localparam int MAX_CHANNELS_DEF      = 8;
  localparam int QUEUE_DEPTH_DEF       = 2;

  localparam int SAMPLE_W   = 25;
  localparam int L16_W      = 16;
  localparam int SEQ_W      = 16;
  localparam int TS_W       = 32;
  localparam int PT_W       = 7;
  localparam int CHANNELS_W = 4;
  localparam int RATE_W     = 18;
  localparam int SSRC_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int BYTE_IDX_W = 4;

  localparam logic [7:0]        RTP_VERSION_BYTE = 8'h80;
  localparam logic [PT_W-1:0]   PT_L16_STEREO    = 7'd10;
  localparam logic [PT_W-1:0]   PT_L16_MONO      = 7'd11;
  localparam logic [PT_W-1:0]   PT_DYNAMIC       = 7'd96;
  localparam logic [RATE_W-1:0] RATE_44K1        = 18'd44100;

  localparam logic [CHANNELS_W-1:0] CHANNELS_RST      = 4'd2;
  localparam logic [RATE_W-1:0]     SAMPLE_RATE_RST   = 18'd48000;
  localparam logic [SSRC_W-1:0]     SSRC_RST          = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_CHANNELS      = 2'd0,
    REG_SAMPLE_RATE   = 2'd1,
    REG_SSRC          = 2'd2,
    REG_OUTPUT_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              hdr;
    logic              marker;
    logic [PT_W-1:0]   pt;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   ts;
    logic [L16_W-1:0]  sample;
    logic              close;
  } desc_t;

  // Clamp to plus or minus one, scale by 32767 and truncate toward zero.
  function automatic logic [L16_W-1:0] to_l16(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] mag;
    logic [23:0]         clamped;
    logic [38:0]         prod;
    logic [14:0]         q;
    mag = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    if (mag > 25'h080_0000) begin
      clamped = 24'h80_0000;
    end else begin
      clamped = mag[23:0];
    end
    prod = {clamped, 15'd0} - {15'd0, clamped};
    q = prod[37:23];
    to_l16 = raw[SAMPLE_W-1] ? (16'd0 - {1'b0, q}) : {1'b0, q};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rtpl16_front.sv */
// ----------------------------------------------------------------------------
// rtpl16_front
// Accepts samples, converts them to L16, tracks frame and packet state and
// queues one descriptor per sample for the byte sequencer while output is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpl16_front #(
  parameter int FRAMES_PER_PACKET = rtpl16_pkg::FRAMES_PER_PACKET_DEF,
  parameter int MAX_CHANNELS      = rtpl16_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [rtpl16_pkg::SAMPLE_W-1:0]      sample,
  input  wire logic                                 period_end,
  input  wire logic [rtpl16_pkg::CHANNELS_W-1:0]    channels,
  input  wire logic [rtpl16_pkg::RATE_W-1:0]        sample_rate,
  input  wire logic                                 output_enable,
  output logic                                      push,
  output rtpl16_pkg::desc_t                         push_desc,
  input  wire logic                                 q_full
);
  import rtpl16_pkg::*;

  localparam int CHW = $clog2(MAX_CHANNELS + 1);
  localparam int FW  = $clog2(FRAMES_PER_PACKET + 1);

  logic [SEQ_W-1:0] seq;
  logic [TS_W-1:0]  ts;
  logic [FW-1:0]    frames;
  logic [CHW-1:0]   pos;
  logic             open;
  logic             first;

  logic [CHW-1:0]   ch_eff;
  logic [CHW-1:0]   pos_inc;
  logic             frame_done;
  logic [FW-1:0]    frames_after;
  logic             close;
  logic [PT_W-1:0]  pt;
  logic             accept;

  always_comb begin
    if (channels == '0) begin
      ch_eff = CHW'(1);
    end else if (32'(channels) > 32'(MAX_CHANNELS)) begin
      ch_eff = CHW'(MAX_CHANNELS);
    end else begin
      ch_eff = CHW'(channels);
    end
  end

  always_comb begin
    if (sample_rate != RATE_44K1) begin
      pt = PT_DYNAMIC;
    end else if (ch_eff == CHW'(1)) begin
      pt = PT_L16_MONO;
    end else begin
      pt = PT_L16_STEREO;
    end
  end

  assign s_tready     = !q_full;
  assign accept       = s_tvalid && s_tready;
  assign pos_inc      = pos + CHW'(1);
  assign frame_done   = (pos_inc >= ch_eff) || period_end;
  assign frames_after = frames + FW'(frame_done);
  assign close        = period_end || (32'(frames_after) >= 32'(FRAMES_PER_PACKET));
  assign push         = accept && output_enable;

  always_comb begin
    push_desc.hdr    = !open;
    push_desc.marker = first;
    push_desc.pt     = pt;
    push_desc.seq    = seq;
    push_desc.ts     = ts;
    push_desc.sample = to_l16(sample);
    push_desc.close  = close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq    <= '0;
      ts     <= '0;
      frames <= '0;
      pos    <= '0;
      open   <= 1'b0;
      first  <= 1'b1;
    end else if (push) begin
      pos   <= frame_done ? '0 : pos_inc;
      first <= period_end;
      if (close) begin
        ts     <= ts + TS_W'(frames_after);
        seq    <= seq + SEQ_W'(1);
        frames <= '0;
        open   <= 1'b0;
      end else begin
        frames <= frames_after;
        open   <= 1'b1;
      end
    end
  end

  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    push && close |=> frames == '0 && !open)
    else $error("packet state not cleared after close");

  a_header_once: assert property (@(posedge clk) disable iff (rst)
    push && !close |=> open && !first)
    else $error("open packet lost after a sample");

endmodule

`default_nettype wire

/* rtl/core/rtpl16_queue.sv */
// ----------------------------------------------------------------------------
// rtpl16_queue
// Short descriptor queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpl16_queue #(
  parameter int DEPTH = rtpl16_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rtpl16_pkg::desc_t push_desc,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output rtpl16_pkg::desc_t      head
);
  import rtpl16_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("descriptor pushed into full queue");

endmodule

`default_nettype wire

/* rtl/core/rtpl16_back.sv */
// ----------------------------------------------------------------------------
// rtpl16_back
// Byte sequencer: walks the queue head through header and sample bytes into
// a registered byte-wide output.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpl16_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              head_valid,
  input  wire rtpl16_pkg::desc_t                 head,
  output logic                                   pop,
  input  wire logic [rtpl16_pkg::SSRC_W-1:0]     ssrc,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [7:0]                             m_tdata,
  output logic                                   m_tlast,
  output logic [0:0]                             m_tuser
);
  import rtpl16_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] BYTE_VER     = 4'd0;
  localparam logic [BYTE_IDX_W-1:0] BYTE_PT      = 4'd1;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SEQ_HI  = 4'd2;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SEQ_LO  = 4'd3;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TS_3    = 4'd4;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TS_2    = 4'd5;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TS_1    = 4'd6;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TS_0    = 4'd7;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SSRC_3  = 4'd8;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SSRC_2  = 4'd9;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SSRC_1  = 4'd10;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SSRC_0  = 4'd11;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SMP_HI  = 4'd12;
  localparam logic [BYTE_IDX_W-1:0] BYTE_SMP_LO  = 4'd13;

  logic                  busy;
  logic [BYTE_IDX_W-1:0] idx;
  logic [BYTE_IDX_W-1:0] cur_idx;
  logic                  load;
  logic [7:0]            byte_sel;

  assign cur_idx = busy ? idx : (head.hdr ? BYTE_VER : BYTE_SMP_HI);
  assign load    = head_valid && (!m_tvalid || m_tready);
  assign pop     = load && (cur_idx == BYTE_SMP_LO);

  always_comb begin
    case (cur_idx)
      BYTE_VER:    byte_sel = RTP_VERSION_BYTE;
      BYTE_PT:     byte_sel = {head.marker, head.pt};
      BYTE_SEQ_HI: byte_sel = head.seq[15:8];
      BYTE_SEQ_LO: byte_sel = head.seq[7:0];
      BYTE_TS_3:   byte_sel = head.ts[31:24];
      BYTE_TS_2:   byte_sel = head.ts[23:16];
      BYTE_TS_1:   byte_sel = head.ts[15:8];
      BYTE_TS_0:   byte_sel = head.ts[7:0];
      BYTE_SSRC_3: byte_sel = ssrc[31:24];
      BYTE_SSRC_2: byte_sel = ssrc[23:16];
      BYTE_SSRC_1: byte_sel = ssrc[15:8];
      BYTE_SSRC_0: byte_sel = ssrc[7:0];
      BYTE_SMP_HI: byte_sel = head.sample[15:8];
      BYTE_SMP_LO: byte_sel = head.sample[7:0];
      default:     byte_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      busy     <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      busy     <= (cur_idx != BYTE_SMP_LO);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx        <= cur_idx + BYTE_IDX_W'(1);
      m_tdata    <= byte_sel;
      m_tuser[0] <= (cur_idx == BYTE_VER);
      m_tlast    <= (cur_idx == BYTE_SMP_LO) && head.close;
    end
  end

  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    pop |=> !busy)
    else $error("sequencer still busy after retiring a descriptor");

  a_start_from_header: assert property (@(posedge clk) disable iff (rst)
    load && !busy |-> (cur_idx == BYTE_VER) == head.hdr)
    else $error("descriptor started at wrong byte");

endmodule

`default_nettype wire

/* rtl/core/rtp_l16_packetizer.sv */
// ----------------------------------------------------------------------------
// rtp_l16_packetizer
// RTP L16 audio packetizer: samples in, RTP packet bytes out.
// ----------------------------------------------------------------------------
// Path: a transferred sample is written into the descriptor queue, and its
//   first byte is then registered onto the output once the sequencer is free.
// Throughput: one output byte per cycle while m_tready is high; each sample gives
//   2 bytes, plus 12 header bytes for the sample that opens a packet.
// Reset: packet state cleared, marker armed, registers to their defaults.
`default_nettype none

module rtp_l16_packetizer #(
  parameter int FRAMES_PER_PACKET = rtpl16_pkg::FRAMES_PER_PACKET_DEF,
  parameter int MAX_CHANNELS      = rtpl16_pkg::MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH       = rtpl16_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [31:0]                        s_tdata,   // sample[24:0], zero fill
  input  wire logic                               s_tlast,   // period_end
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [7:0]                              m_tdata,   // data_byte
  output logic                                    m_tlast,   // packet_end
  output logic [0:0]                              m_tuser,   // packet_start
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [rtpl16_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rtpl16_pkg::*;

  logic [CHANNELS_W-1:0] channels;
  logic [RATE_W-1:0]     sample_rate;
  logic [SSRC_W-1:0]     ssrc;
  logic                  output_enable;

  logic   push;
  desc_t  push_desc;
  logic   q_full;
  logic   pop;
  logic   head_valid;
  desc_t  head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels      <= CHANNELS_RST;
      sample_rate   <= SAMPLE_RATE_RST;
      ssrc          <= SSRC_RST;
      output_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHANNELS:      channels      <= cfg_data[CHANNELS_W-1:0];
        REG_SAMPLE_RATE:   sample_rate   <= cfg_data[RATE_W-1:0];
        REG_SSRC:          ssrc          <= cfg_data[SSRC_W-1:0];
        REG_OUTPUT_ENABLE: output_enable <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  rtpl16_front #(
    .FRAMES_PER_PACKET (FRAMES_PER_PACKET),
    .MAX_CHANNELS      (MAX_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .sample        (s_tdata[SAMPLE_W-1:0]),
    .period_end    (s_tlast),
    .channels      (channels),
    .sample_rate   (sample_rate),
    .output_enable (output_enable),
    .push          (push),
    .push_desc     (push_desc),
    .q_full        (q_full)
  );

  rtpl16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rtpl16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ssrc       (ssrc),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire
